// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared immediate-implication and next-cycle-implication checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define XRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/xrs_pkg.sv =====
// ---------------------------------------------------------------------------
// xrs_pkg
// Constants and the generator step for the range-draw and shuffle block.
// ---------------------------------------------------------------------------
package xrs_pkg;

    localparam int MAX_ELEMENTS_DEF  = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int ELEM_W_MAX        = 64;

    localparam logic [31:0] SEED_RESET = 32'd123456789;
    localparam int          SHIFT_A    = 13;
    localparam int          SHIFT_B    = 17;
    localparam int          SHIFT_C    = 5;

    // Largest span that a range draw accepts.
    localparam logic [32:0] SPAN_MAX = 33'd2147483647;

    localparam int DIV_STEPS = 32;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

// ===== hw/rtl/xorshift_range_and_shuffle_top.sv =====
// ---------------------------------------------------------------------------
// xorshift_range_and_shuffle_top
// Xorshift generator with range draws and an in-memory element shuffle.
// ---------------------------------------------------------------------------
// Requests arrive on the input channel (i_in_valid, o_in_stall) and results
// leave on the output channel (o_out_valid, i_out_stall); a transfer takes
// place when valid is high and stall is low. A seed write reloads the
// generator and must only be made while the block is idle.
// A range draw gives one result: the modulo runs one quotient bit per cycle
// in a shared 32-step divider, and the remainder is added to the lower bound.
// The next request is taken only once the draw result is registered.
// Inverted or over-wide ranges skip the divider and give the lower bound
// from the output state.
// Loads without the last mark are stored (if room is left); no result.
// The last load shuffles the n stored elements, each index from the top
// down to 1 needing one divider pass and two reads and two writes of the
// store, then emits the n elements, each through a read and a load state.
// The block takes a new request only when idle; a finished result waits in
// the output register while the next request is accepted.
// A stalled receiver holds the output register and pauses the emission.
// Reset sets the generator to 123456789 and empties the store; there is no
// clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xorshift_range_and_shuffle_top #(
    parameter int MAX_ELEMENTS  = xrs_pkg::MAX_ELEMENTS_DEF,
    parameter int ELEMENT_WIDTH = xrs_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seed_we,
    input  logic [31:0]        i_seed_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic [31:0]        i_element,
    input  logic               i_last_element,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_draw_value,
    output logic [31:0]        o_element_out,
    output logic               o_last,
    output logic               o_dropped
);

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int CW   = $clog2(MAX_ELEMENTS + 1);
    localparam int EW   = ELEMENT_WIDTH;
    localparam int WIDE = xrs_pkg::ELEM_W_MAX;
    localparam int DCW  = $clog2(xrs_pkg::DIV_STEPS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DRAW_DIV = 4'd1;
    localparam logic [3:0] S_DRAW_OUT = 4'd2;
    localparam logic [3:0] S_SH_DIV   = 4'd3;
    localparam logic [3:0] S_SH_RDI   = 4'd4;
    localparam logic [3:0] S_SH_RDJ   = 4'd5;
    localparam logic [3:0] S_SH_WRI   = 4'd6;
    localparam logic [3:0] S_SH_WRJ   = 4'd7;
    localparam logic [3:0] S_EM_RD    = 4'd8;
    localparam logic [3:0] S_EM_LD    = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [31:0]       r_gen, n_gen;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_top, n_top;
    logic [AW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_k, n_k;
    logic signed [31:0] r_lo, n_lo;
    logic [31:0]       r_dvd, n_dvd;
    logic [31:0]       r_dvs, n_dvs;
    logic [31:0]       r_rem, n_rem;
    logic [DCW-1:0]    r_dcnt, n_dcnt;
    logic [EW-1:0]     r_tmp, n_tmp;

    logic              r_out_valid, n_out_valid;
    logic signed [31:0] r_draw_value, n_draw_value;
    logic [31:0]       r_element_out, n_element_out;
    logic              r_last, n_last;
    logic              r_dropped, n_dropped;

    logic [EW-1:0]     r_mem [MAX_ELEMENTS];
    logic [EW-1:0]     r_rd_data;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    logic              w_accept;
    logic              w_out_free;
    logic [31:0]       w_gen_next;
    logic [32:0]       w_diff;
    logic [32:0]       w_span;
    logic              w_inverted;
    logic              w_too_wide;
    logic [31:0]       w_rem_sh;
    logic [31:0]       w_rem_nx;
    logic              w_div_done;
    logic [WIDE-1:0]   w_elem_wide;
    logic [WIDE-1:0]   w_rd_wide;

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_gen_next    = xrs_pkg::xorshift32(r_gen);

    assign w_diff     = {i_range_high[31], i_range_high} - {i_range_low[31], i_range_low};
    assign w_span     = w_diff + 33'd1;
    assign w_inverted = (i_range_high < i_range_low);
    assign w_too_wide = (w_span > xrs_pkg::SPAN_MAX);

    assign w_rem_sh   = {r_rem[30:0], r_dvd[31]};
    assign w_rem_nx   = (w_rem_sh >= r_dvs) ? (w_rem_sh - r_dvs) : w_rem_sh;
    assign w_div_done = (r_dcnt == DCW'(xrs_pkg::DIV_STEPS - 1));

    assign w_elem_wide = WIDE'(i_element);
    assign w_rd_wide   = WIDE'(r_rd_data);

    always_comb begin
        n_state       = r_state;
        n_gen         = r_gen;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_top         = r_top;
        n_i           = r_i;
        n_j           = r_j;
        n_k           = r_k;
        n_lo          = r_lo;
        n_dvd         = r_dvd;
        n_dvs         = r_dvs;
        n_rem         = r_rem;
        n_dcnt        = r_dcnt;
        n_tmp         = r_tmp;
        n_out_valid   = r_out_valid && i_out_stall;
        n_draw_value  = r_draw_value;
        n_element_out = r_element_out;
        n_last        = r_last;
        n_dropped     = r_dropped;
        w_we          = 1'b0;
        w_waddr       = r_i;
        w_wdata       = r_rd_data;
        w_re          = 1'b0;
        w_raddr       = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == xrs_pkg::OP_DRAW) begin
                        n_lo  = i_range_low;
                        n_rem = 32'd0;
                        if (w_inverted || w_too_wide) begin
                            n_state = S_DRAW_OUT;
                        end else begin
                            n_gen   = w_gen_next;
                            n_dvd   = w_gen_next;
                            n_dvs   = w_span[31:0];
                            n_dcnt  = '0;
                            n_state = S_DRAW_DIV;
                        end
                    end else begin
                        if (r_count < CW'(MAX_ELEMENTS)) begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            w_wdata = w_elem_wide[EW-1:0];
                            n_count = r_count + CW'(1);
                            n_top   = r_count[AW-1:0];
                        end else begin
                            n_ovf = 1'b1;
                            n_top = AW'(MAX_ELEMENTS - 1);
                        end
                        if (i_last_element) begin
                            if (n_top == '0) begin
                                n_k     = '0;
                                n_state = S_EM_RD;
                            end else begin
                                n_i     = n_top;
                                n_gen   = w_gen_next;
                                n_dvd   = w_gen_next;
                                n_dvs   = 32'(n_top) + 32'd1;
                                n_rem   = 32'd0;
                                n_dcnt  = '0;
                                n_state = S_SH_DIV;
                            end
                        end
                    end
                end
                if (i_seed_we) begin
                    n_gen = i_seed_data;
                end
            end
            S_DRAW_DIV: begin
                n_dvd  = r_dvd << 1;
                n_rem  = w_rem_nx;
                n_dcnt = r_dcnt + DCW'(1);
                if (w_div_done) begin
                    n_state = S_DRAW_OUT;
                end
            end
            S_DRAW_OUT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_draw_value  = r_lo + r_rem;
                    n_element_out = 32'd0;
                    n_last        = 1'b1;
                    n_dropped     = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            S_SH_DIV: begin
                n_dvd  = r_dvd << 1;
                n_rem  = w_rem_nx;
                n_dcnt = r_dcnt + DCW'(1);
                if (w_div_done) begin
                    n_j     = w_rem_nx[AW-1:0];
                    n_state = S_SH_RDI;
                end
            end
            S_SH_RDI: begin
                w_re    = 1'b1;
                w_raddr = r_i;
                n_state = S_SH_RDJ;
            end
            S_SH_RDJ: begin
                w_re    = 1'b1;
                w_raddr = r_j;
                n_tmp   = r_rd_data;
                n_state = S_SH_WRI;
            end
            S_SH_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rd_data;
                n_state = S_SH_WRJ;
            end
            S_SH_WRJ: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_tmp;
                if (r_i == AW'(1)) begin
                    n_k     = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_gen   = w_gen_next;
                    n_dvd   = w_gen_next;
                    n_dvs   = 32'(r_i);
                    n_rem   = 32'd0;
                    n_dcnt  = '0;
                    n_state = S_SH_DIV;
                end
            end
            S_EM_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k;
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_draw_value  = 32'sd0;
                    n_element_out = w_rd_wide[31:0];
                    n_last        = (r_k == r_top);
                    n_dropped     = r_ovf;
                    if (r_k == r_top) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= xrs_pkg::SEED_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top         <= n_top;
        r_i           <= n_i;
        r_j           <= n_j;
        r_k           <= n_k;
        r_lo          <= n_lo;
        r_dvd         <= n_dvd;
        r_dvs         <= n_dvs;
        r_rem         <= n_rem;
        r_dcnt        <= n_dcnt;
        r_tmp         <= n_tmp;
        r_draw_value  <= n_draw_value;
        r_element_out <= n_element_out;
        r_last        <= n_last;
        r_dropped     <= n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_draw_value  = r_draw_value;
    assign o_element_out = r_element_out;
    assign o_last        = r_last;
    assign o_dropped     = r_dropped;

    `XRS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ELEMENTS))
    `XRS_ASSERT_NOW(a_swap_index, i_clk, i_rst_n, r_state == S_SH_RDI, r_j <= r_i)
    `XRS_ASSERT_NEXT(a_inverted_draw, i_clk, i_rst_n,
        w_accept && (i_operation == xrs_pkg::OP_DRAW) && w_inverted,
        (r_state == S_DRAW_OUT) && (r_rem == 32'd0) && (r_gen == $past(r_gen)))
    `XRS_ASSERT_NEXT(a_run_end, i_clk, i_rst_n,
        (r_state == S_EM_LD) && w_out_free && (r_k == r_top),
        (r_state == S_IDLE) && (r_count == '0) && !r_ovf && r_last)

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the xorshift range-draw and shuffle block.
// ---------------------------------------------------------------------------
// Draw and load requests are driven with random gaps, and results are taken
// with random stalls. A scoreboard keeps its own generator state and element
// store, predicts every result when its request is accepted, and compares
// each result as it leaves the block. The seed is changed between phases,
// only once the block has gone idle.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH      = xrs_pkg::MAX_ELEMENTS_DEF;
    localparam int SETTLE_CYCLES    = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TIMEOUT_NS       = 5_000_000;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] draw_value;
        logic [31:0]        element_out;
        logic               last;
        logic               dropped;
    } t_result;

    class t_scoreboard;
        logic [31:0] gen_state;
        logic [31:0] elements [STORE_DEPTH];
        int          element_count;
        bit          overflow_seen;
        t_result     results_due [$];
        int          mismatches;

        function new();
            gen_state     = xrs_pkg::SEED_RESET;
            element_count = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
        endfunction

        function void load_seed(input logic [31:0] value);
            gen_state = value;
        endfunction

        function logic [31:0] next_xorshift();
            logic [31:0] s;
            s = gen_state;
            s = s ^ (s << xrs_pkg::SHIFT_A);
            s = s ^ (s >> xrs_pkg::SHIFT_B);
            s = s ^ (s << xrs_pkg::SHIFT_C);
            gen_state = s;
            return s;
        endfunction

        function logic [31:0] bounded_draw(input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
            longint      span;
            logic [31:0] offset;
            span = longint'(hi) - longint'(lo) + 1;
            if (hi < lo || span > longint'(xrs_pkg::SPAN_MAX)) begin
                return lo;
            end
            offset = next_xorshift() % span[31:0];
            return lo + offset;
        endfunction

        function void note_request(input logic op, input logic signed [31:0] lo,
                                   input logic signed [31:0] hi,
                                   input logic [31:0] elem, input logic last_mark);
            t_result     r;
            int          i;
            int          j;
            logic [31:0] swap;
            if (op == xrs_pkg::OP_DRAW) begin
                r.draw_value  = bounded_draw(lo, hi);
                r.element_out = '0;
                r.last        = 1'b1;
                r.dropped     = 1'b0;
                results_due.push_back(r);
                return;
            end
            if (element_count < STORE_DEPTH) begin
                elements[element_count] = elem;
                element_count++;
            end else begin
                overflow_seen = 1'b1;
            end
            if (!last_mark) begin
                return;
            end
            for (i = element_count - 1; i > 0; i--) begin
                j           = bounded_draw(0, i);
                swap        = elements[i];
                elements[i] = elements[j];
                elements[j] = swap;
            end
            for (i = 0; i < element_count; i++) begin
                r.draw_value  = '0;
                r.element_out = elements[i];
                r.last        = (i == element_count - 1);
                r.dropped     = overflow_seen;
                results_due.push_back(r);
            end
            element_count = 0;
            overflow_seen = 1'b0;
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (results_due.size() == 0) begin
                $display("%0t ns: unexpected result %0d %08h last=%b dropped=%b",
                         $time, got.draw_value, got.element_out, got.last, got.dropped);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            if (want !== got) begin
                $display("%0t ns: expected %0d %08h %b %b, got %0d %08h %b %b",
                         $time, want.draw_value, want.element_out, want.last,
                         want.dropped, got.draw_value, got.element_out, got.last,
                         got.dropped);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_seed_we;
    logic [31:0]        i_seed_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_operation;
    logic signed [31:0] i_range_low;
    logic signed [31:0] i_range_high;
    logic [31:0]        i_element;
    logic               i_last_element;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_draw_value;
    logic [31:0]        o_element_out;
    logic               o_last;
    logic               o_dropped;

    t_scoreboard        board;
    int                 lead_gap = 0;
    int                 requests_sent = 0;
    bit                 quiet_mode = 1'b0;
    bit                 long_hold_wanted = 1'b0;

    xorshift_range_and_shuffle_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_data    (i_seed_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_element      (i_element),
        .i_last_element (i_last_element),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_draw_value   (o_draw_value),
        .o_element_out  (o_element_out),
        .o_last         (o_last),
        .o_dropped      (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[xorshift_range_and_shuffle_top] ERROR");
        $finish;
    end

    function automatic int idle_cycles();
        if (quiet_mode) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Results are taken at the rising edge; the stall that follows each one
    // is driven from the next falling edge.
    initial begin : result_side
        int      hold;
        t_result got;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_draw_value, o_element_out, o_last, o_dropped};
                board.check_result(got);
                if (long_hold_wanted) begin
                    hold             = LONG_HOLD_CYCLES;
                    long_hold_wanted = 1'b0;
                end else begin
                    hold = idle_cycles();
                end
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic op, input logic signed [31:0] lo,
                                input logic signed [31:0] hi,
                                input logic [31:0] elem, input logic last_mark);
        repeat (lead_gap) @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_range_low    <= lo;
        i_range_high   <= hi;
        i_element      <= elem;
        i_last_element <= last_mark;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(op, lo, hi, elem, last_mark);
        requests_sent++;
        @(negedge i_clk);
        lead_gap = idle_cycles();
        if (lead_gap != 0) begin
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_draw(input logic signed [31:0] lo, input logic signed [31:0] hi);
        send_request(xrs_pkg::OP_DRAW, lo, hi, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_load(input logic [31:0] elem, input logic last_mark);
        send_request(xrs_pkg::OP_LOAD, $urandom, $urandom, elem, last_mark);
    endtask

    task automatic random_draw();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        longint             top;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 2))
            0: ;
            1: begin
                top = longint'(lo) + longint'($urandom_range(0, 1000));
                hi  = (top > longint'(INT_MAX)) ? INT_MAX : top[31:0];
            end
            default: begin
                lo = -int'($urandom_range(0, 1 << 20));
                hi = int'($urandom_range(0, 1 << 30));
            end
        endcase
        send_draw(lo, hi);
    endtask

    task automatic random_sequence();
        int pick;
        int n;
        int k;
        quiet_mode = ($urandom_range(0, 5) == 0);
        pick       = $urandom_range(0, 99);
        if (pick < 50) begin
            random_draw();
        end else begin
            n = (pick < 88) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    random_draw();
                end
                send_load(pick_element(), k == n - 1);
            end
        end
    endtask

    // The sender stops and waits for every result, then lets the block settle
    // in case a load that gives no result is still being stored.
    task automatic wait_until_idle();
        if (lead_gap == 0) begin
            i_in_valid <= 1'b0;
        end
        lead_gap = 0;
        while (board.results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_until_idle();
        i_seed_we   <= 1'b1;
        i_seed_data <= value;
        board.load_seed(value);
        @(negedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    task automatic random_phase(input logic [31:0] seed_value, input int count);
        int phase_start;
        write_seed(seed_value);
        phase_start = requests_sent;
        while (requests_sent - phase_start < count) random_sequence();
    endtask

    initial begin : stimulus
        int k;
        int extra;
        i_rst_n        = 1'b0;
        i_seed_we      = 1'b0;
        i_seed_data    = '0;
        i_in_valid     = 1'b0;
        i_operation    = xrs_pkg::OP_DRAW;
        i_range_low    = '0;
        i_range_high   = '0;
        i_element      = '0;
        i_last_element = 1'b0;
        board          = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset seed: span of one, full and over-wide spans, inverted range,
        // the widest span allowed, then single, three and two element loads.
        send_draw(0, 0);
        send_draw(INT_MIN, INT_MAX);
        send_draw(5, -5);
        send_draw(0, 32'sh7fff_fffe);
        send_draw(INT_MIN, -2);
        send_draw(INT_MIN, -1);
        send_draw(INT_MAX, INT_MAX);
        send_draw(-100, 100);
        send_draw(INT_MIN, INT_MIN);
        send_load(32'hffff_ffff, 1'b1);
        send_load(32'h0000_0000, 1'b0);
        send_load(32'hffff_ffff, 1'b0);
        send_load(32'h0001_2345, 1'b1);
        send_load(32'ha5a5_a5a5, 1'b0);
        send_load(32'h5a5a_5a5a, 1'b1);

        // A zero generator state never leaves zero.
        write_seed(32'h0000_0000);
        send_draw(-1000, 1000);
        send_draw(0, 32'sh7fff_fffe);
        send_load(32'h1111_1111, 1'b0);
        send_load(32'h2222_2222, 1'b0);
        send_load(32'h3333_3333, 1'b1);

        write_seed(32'hffff_ffff);
        send_draw(-7, 7);
        send_load(32'h0000_0001, 1'b0);
        send_load(32'h0000_0002, 1'b1);

        // The long receiver hold starts on the first result of the next phase.
        wait_until_idle();
        long_hold_wanted = 1'b1;
        random_phase($urandom, 50);

        // Fill the store, then offer a few more requests that are dropped;
        // the last mark sits on a dropped request.
        write_seed(32'h0000_0001);
        quiet_mode = 1'b0;
        extra      = $urandom_range(1, 4);
        for (k = 0; k < STORE_DEPTH + extra; k++) begin
            send_load(pick_element(), k == STORE_DEPTH + extra - 1);
        end
        random_phase(32'h8000_0000, 30);
        random_phase($urandom, 50);

        wait_until_idle();
        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.results_due.size() == 0) begin
            $display("[xorshift_range_and_shuffle_top] OK");
        end else begin
            $display("[xorshift_range_and_shuffle_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== xorshift_range_and_shuffle_top.f =====
+incdir+hw/rtl
hw/rtl/xrs_pkg.sv
hw/rtl/xorshift_range_and_shuffle_top.sv
sim/testbench.sv
